// ----- design/mm_pkg.sv -----
// shared types and constants for the matrix multiply block
package mm_pkg;

    localparam int DIM_W     = 4;
    localparam int IDX_W     = 3;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 36;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_OF_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_OF_B = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic signed [ACC_W-1:0] SAT_MAX = 36'sh07FFFFFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = 36'shF80000000;

    typedef struct packed {
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nk;
        logic [DIM_W-1:0] nc;
    } dims_t;

    typedef struct packed {
        logic computing;
        logic res_wr;
    } bk_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WAIT,
        BK_ISSUE
    } bk_state_t;

endpackage

// ----- design/matrix_multiply.sv -----
// top level of the dense matrix multiply block
//
// elements of a (row-major, rows_of_a x inner_dim) and then of b (row-major,
// inner_dim x cols_of_b) are written as signed q8.8 words: a word is taken
// when push is high and full is low. after the last word of b the block
// emits every element of c = a x b in row-major order as q16.16, saturated
// to 32 bits, with its row, column and a last flag; a result word is shown
// while empty is low and leaves when pop is high.
// dimensions are written through the cfg port (index 0 rows_of_a, 1
// inner_dim, 2 cols_of_b); the user must write them only while the block is
// idle; the block does not enforce it. a write restarts the load. loads
// go through a 4-word queue to the operand stores at one word a cycle while
// the back end is idle. once the last b word is stored, one shared
// multiply-accumulate forms each result element in turn: it reads the
// inner_dim operand pairs, then waits for the pipeline to drain and the
// result word to be popped. words of the next load are queued meanwhile
// until the queue is full. a stalled pop holds the result register and
// stops the multiply-accumulate. reset sets all dimensions to 8 and clears
// the load position; the operand stores are not cleared.
module matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]     cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [mm_pkg::ELEM_W-1:0]    element,
    output logic                         empty,
    input  logic                         pop,
    output logic [mm_pkg::PROD_W-1:0]    product_element,
    output logic [mm_pkg::IDX_W-1:0]     out_row,
    output logic [mm_pkg::IDX_W-1:0]     out_col,
    output logic                         last
);

    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
    localparam int Q_W     = ADDR_W + mm_pkg::ELEM_W + 2;
    localparam int Q_DEPTH = 4;

    mm_pkg::dims_t      dims;
    mm_pkg::bk_status_t bk_status;
    logic               q_wr;
    logic [Q_W-1:0]     q_wdata;
    logic               q_full;
    logic               q_pop;
    logic [Q_W-1:0]     q_rdata;
    logic               q_valid;

    mm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .element   (element),
        .q_wr      (q_wr),
        .q_wdata   (q_wdata),
        .q_full    (q_full),
        .dims      (dims)
    );

    mm_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr),
        .wdata     (q_wdata),
        .full      (q_full),
        .rd_en     (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_valid)
    );

    mm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .dims            (dims),
        .q_valid         (q_valid),
        .q_rdata         (q_rdata),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .product_element (product_element),
        .out_row         (out_row),
        .out_col         (out_col),
        .last            (last),
        .status          (bk_status)
    );

    // stores are not written while a product is being formed
    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.computing |-> !q_pop)
        else $error("queue read while computing");

    // a new result only lands in an empty result register
    a_result_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.res_wr |-> empty)
        else $error("result overwrites waiting word");

    // the last word carries the bottom right corner
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (out_row == mm_pkg::IDX_W'(dims.nr - mm_pkg::DIM_W'(1))
                              && out_col == mm_pkg::IDX_W'(dims.nc - mm_pkg::DIM_W'(1))))
        else $error("last flag off the corner");

endmodule

// ----- design/mm_ram.sv -----
// generic single-write, registered-read ram
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mm_queue.sv -----
// small fifo between the load front end and the compute back end
module mm_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rdata,
    output logic             not_empty
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rdata     = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/mm_front.sv -----
// load front end: config registers, element counting and a/b classification
module mm_front #(
    parameter int MAX_DIM = 8,
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM),
    localparam int Q_W    = ADDR_W + mm_pkg::ELEM_W + 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]     cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [mm_pkg::ELEM_W-1:0]    element,
    output logic                         q_wr,
    output logic [Q_W-1:0]               q_wdata,
    input  logic                         q_full,
    output mm_pkg::dims_t                dims
);

    localparam int SZ_W = ADDR_W + 1;

    logic [mm_pkg::DIM_W-1:0] rows_reg;
    logic [mm_pkg::DIM_W-1:0] inner_reg;
    logic [mm_pkg::DIM_W-1:0] cols_reg;
    logic                     phase_b_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [SZ_W-1:0]          size_a;
    logic [SZ_W-1:0]          size_b;
    logic                     at_end;
    logic                     last_elem;
    logic                     accept;
    logic                     cfg_we;

    function automatic logic [mm_pkg::DIM_W-1:0] clamp_dim(input logic [mm_pkg::DIM_W-1:0] v);
        logic [mm_pkg::DIM_W-1:0] r;
        if (v == '0)
        begin
            r = mm_pkg::DIM_W'(1);
        end
        else if (v > mm_pkg::DIM_W'(MAX_DIM))
        begin
            r = mm_pkg::DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign dims.nr = clamp_dim(rows_reg);
    assign dims.nk = clamp_dim(inner_reg);
    assign dims.nc = clamp_dim(cols_reg);

    assign size_a = SZ_W'(dims.nr) * SZ_W'(dims.nk);
    assign size_b = SZ_W'(dims.nk) * SZ_W'(dims.nc);

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign full      = q_full;
    assign accept    = push && !q_full;

    assign at_end    = phase_b_reg ? ({1'b0, addr_reg} == size_b - SZ_W'(1))
                                   : ({1'b0, addr_reg} == size_a - SZ_W'(1));
    assign last_elem = phase_b_reg && at_end;

    assign q_wr    = accept;
    assign q_wdata = {phase_b_reg, last_elem, addr_reg, element};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= mm_pkg::DIM_RESET;
            inner_reg   <= mm_pkg::DIM_RESET;
            cols_reg    <= mm_pkg::DIM_RESET;
            phase_b_reg <= 1'b0;
            addr_reg    <= '0;
        end
        else if (cfg_we && (cfg_index == mm_pkg::REG_ROWS_OF_A
                            || cfg_index == mm_pkg::REG_INNER_DIM
                            || cfg_index == mm_pkg::REG_COLS_OF_B))
        begin
            unique case (cfg_index)
                mm_pkg::REG_ROWS_OF_A: rows_reg  <= cfg_data;
                mm_pkg::REG_INNER_DIM: inner_reg <= cfg_data;
                mm_pkg::REG_COLS_OF_B: cols_reg  <= cfg_data;
                default: ;
            endcase
            // a register write restarts the load
            phase_b_reg <= 1'b0;
            addr_reg    <= '0;
        end
        else if (accept)
        begin
            if (at_end)
            begin
                addr_reg    <= '0;
                phase_b_reg <= !phase_b_reg;
            end
            else
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end
        end
    end

endmodule

// ----- design/mm_back.sv -----
// compute back end: operand stores, shared multiply-accumulate, result register
module mm_back #(
    parameter int MAX_DIM = 8,
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM),
    localparam int Q_W    = ADDR_W + mm_pkg::ELEM_W + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mm_pkg::dims_t                 dims,
    input  logic                          q_valid,
    input  logic [Q_W-1:0]                q_rdata,
    output logic                          q_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [mm_pkg::PROD_W-1:0]     product_element,
    output logic [mm_pkg::IDX_W-1:0]      out_row,
    output logic [mm_pkg::IDX_W-1:0]      out_col,
    output logic                          last,
    output mm_pkg::bk_status_t            status
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    mm_pkg::bk_state_t state_reg;
    mm_pkg::bk_state_t state_next;

    logic                       e_is_b;
    logic                       e_last;
    logic [ADDR_W-1:0]          e_addr;
    logic [mm_pkg::ELEM_W-1:0]  e_data;

    logic [mm_pkg::IDX_W-1:0]   i_reg, i_next;
    logic [mm_pkg::IDX_W-1:0]   j_reg, j_next;
    logic [mm_pkg::IDX_W-1:0]   k_reg, k_next;
    logic [ADDR_W-1:0]          a_row_reg, a_row_next;
    logic [ADDR_W-1:0]          a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0]          b_addr_reg, b_addr_next;
    logic                       done_reg, done_next;
    logic                       issue;
    logic                       k_last;
    logic                       j_last;
    logic                       i_last;
    logic                       pipe_idle;

    logic [mm_pkg::ELEM_W-1:0]  a_rdata;
    logic [mm_pkg::ELEM_W-1:0]  b_rdata;

    logic                       p1_valid_reg;
    logic                       p1_first_reg;
    logic                       p1_lastk_reg;
    logic                       p1_end_reg;
    logic [mm_pkg::IDX_W-1:0]   p1_row_reg;
    logic [mm_pkg::IDX_W-1:0]   p1_col_reg;

    logic                       p2_valid_reg;
    logic                       p2_first_reg;
    logic                       p2_lastk_reg;
    logic                       p2_end_reg;
    logic [mm_pkg::IDX_W-1:0]   p2_row_reg;
    logic [mm_pkg::IDX_W-1:0]   p2_col_reg;
    logic signed [mm_pkg::PROD_W-1:0] prod_reg;

    logic signed [mm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mm_pkg::ACC_W-1:0]  sum;
    logic signed [mm_pkg::PROD_W-1:0] sat_value;
    logic                       res_wr;

    logic                       out_valid_reg;
    logic [mm_pkg::PROD_W-1:0]  out_value_reg;
    logic [mm_pkg::IDX_W-1:0]   out_row_reg;
    logic [mm_pkg::IDX_W-1:0]   out_col_reg;
    logic                       out_last_reg;

    assign e_is_b = q_rdata[ADDR_W + mm_pkg::ELEM_W + 1];
    assign e_last = q_rdata[ADDR_W + mm_pkg::ELEM_W];
    assign e_addr = q_rdata[ADDR_W + mm_pkg::ELEM_W - 1 : mm_pkg::ELEM_W];
    assign e_data = q_rdata[mm_pkg::ELEM_W-1:0];

    mm_ram #(
        .WIDTH (mm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (q_pop && !e_is_b),
        .waddr (e_addr),
        .wdata (e_data),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    mm_ram #(
        .WIDTH (mm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (q_pop && e_is_b),
        .waddr (e_addr),
        .wdata (e_data),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    assign k_last    = (mm_pkg::DIM_W'(k_reg) == dims.nk - mm_pkg::DIM_W'(1));
    assign j_last    = (mm_pkg::DIM_W'(j_reg) == dims.nc - mm_pkg::DIM_W'(1));
    assign i_last    = (mm_pkg::DIM_W'(i_reg) == dims.nr - mm_pkg::DIM_W'(1));
    assign pipe_idle = !p1_valid_reg && !p2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        a_row_next  = a_row_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        done_next   = done_reg;
        q_pop       = 1'b0;
        issue       = 1'b0;
        unique case (state_reg)
            mm_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (e_last)
                    begin
                        state_next = mm_pkg::BK_WAIT;
                        i_next     = '0;
                        j_next     = '0;
                        a_row_next = '0;
                        done_next  = 1'b0;
                    end
                end
            end
            mm_pkg::BK_WAIT:
            begin
                if (pipe_idle && !out_valid_reg)
                begin
                    if (done_reg)
                    begin
                        state_next = mm_pkg::BK_IDLE;
                    end
                    else
                    begin
                        state_next  = mm_pkg::BK_ISSUE;
                        k_next      = '0;
                        a_addr_next = a_row_reg;
                        b_addr_next = ADDR_W'(j_reg);
                    end
                end
            end
            mm_pkg::BK_ISSUE:
            begin
                issue       = 1'b1;
                k_next      = k_reg + mm_pkg::IDX_W'(1);
                a_addr_next = a_addr_reg + ADDR_W'(1);
                b_addr_next = b_addr_reg + ADDR_W'(dims.nc);
                if (k_last)
                begin
                    state_next = mm_pkg::BK_WAIT;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            i_next     = i_reg + mm_pkg::IDX_W'(1);
                            a_row_next = a_row_reg + ADDR_W'(dims.nk);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + mm_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = mm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            a_row_reg     <= '0;
            a_addr_reg    <= '0;
            b_addr_reg    <= '0;
            done_reg      <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            a_row_reg    <= a_row_next;
            a_addr_reg   <= a_addr_next;
            b_addr_reg   <= b_addr_next;
            done_reg     <= done_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            if (res_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // product, accumulate and saturate
    assign sum = (p2_first_reg ? '0 : acc_reg) + mm_pkg::ACC_W'(prod_reg);

    always_comb
    begin
        if (sum > mm_pkg::SAT_MAX)
        begin
            sat_value = mm_pkg::SAT_MAX[mm_pkg::PROD_W-1:0];
        end
        else if (sum < mm_pkg::SAT_MIN)
        begin
            sat_value = mm_pkg::SAT_MIN[mm_pkg::PROD_W-1:0];
        end
        else
        begin
            sat_value = sum[mm_pkg::PROD_W-1:0];
        end
    end

    assign res_wr = p2_valid_reg && p2_lastk_reg;

    always_ff @(posedge clk)
    begin
        p1_first_reg <= (k_reg == '0);
        p1_lastk_reg <= k_last;
        p1_end_reg   <= i_last && j_last;
        p1_row_reg   <= i_reg;
        p1_col_reg   <= j_reg;

        prod_reg     <= $signed(a_rdata) * $signed(b_rdata);
        p2_first_reg <= p1_first_reg;
        p2_lastk_reg <= p1_lastk_reg;
        p2_end_reg   <= p1_end_reg;
        p2_row_reg   <= p1_row_reg;
        p2_col_reg   <= p1_col_reg;

        if (p2_valid_reg)
        begin
            acc_reg <= sum;
        end
        if (res_wr)
        begin
            out_value_reg <= sat_value;
            out_row_reg   <= p2_row_reg;
            out_col_reg   <= p2_col_reg;
            out_last_reg  <= p2_end_reg;
        end
    end

    assign empty           = !out_valid_reg;
    assign product_element = out_value_reg;
    assign out_row         = out_row_reg;
    assign out_col         = out_col_reg;
    assign last            = out_last_reg;

    assign status.computing = (state_reg != mm_pkg::BK_IDLE);
    assign status.res_wr    = res_wr;

endmodule

// ----- tb/tb_matrix_multiply.sv -----
// testbench for the matrix multiply block: directed and random loads checked against a predictor
`timescale 1ns / 100ps

module tb_matrix_multiply;

    localparam int MAX_DIM       = 8;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [mm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [2:0] SET_ROWS  = 3'b001;
    localparam logic [2:0] SET_INNER = 3'b010;
    localparam logic [2:0] SET_COLS  = 3'b100;
    localparam logic [2:0] SET_ALL   = 3'b111;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [mm_pkg::PROD_W-1:0] value;
        logic [mm_pkg::IDX_W-1:0]  row;
        logic [mm_pkg::IDX_W-1:0]  col;
        logic                      last;
    } product_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [mm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mm_pkg::DIM_W-1:0]     cfg_data = '0;
    logic                         push = 1'b0;
    logic                         full;
    logic [mm_pkg::ELEM_W-1:0]    element = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic [mm_pkg::PROD_W-1:0]    product_element;
    logic [mm_pkg::IDX_W-1:0]     out_row;
    logic [mm_pkg::IDX_W-1:0]     out_col;
    logic                         last;

    // predictor state
    logic [mm_pkg::DIM_W-1:0]         dim_rows = mm_pkg::DIM_RESET;
    logic [mm_pkg::DIM_W-1:0]         dim_inner = mm_pkg::DIM_RESET;
    logic [mm_pkg::DIM_W-1:0]         dim_cols = mm_pkg::DIM_RESET;
    logic signed [mm_pkg::ELEM_W-1:0] a_store [STORE_DEPTH];
    logic signed [mm_pkg::ELEM_W-1:0] b_store [STORE_DEPTH];
    int                               load_pos = 0;

    product_word_t pending_products [$];
    int            mismatch_count = 0;
    int            words_sent = 0;
    int            cycle_count = 0;
    int            pop_gap = 0;
    bit            idle_enabled = 1'b1;

    matrix_multiply #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .element         (element),
        .empty           (empty),
        .pop             (pop),
        .product_element (product_element),
        .out_row         (out_row),
        .out_col         (out_col),
        .last            (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("matrix_multiply regression: fail");
            $finish;
        end
    end

    function automatic int clamp_dim(input logic [mm_pkg::DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [mm_pkg::DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return mm_pkg::DIM_W'($urandom_range(MAX_DIM + 1, 15));
        if (r == 2)
            return mm_pkg::DIM_W'($urandom_range(5, MAX_DIM));
        return mm_pkg::DIM_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [mm_pkg::ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return mm_pkg::ELEM_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic apply_config(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mm_pkg::DIM_W-1:0] val);
        case (idx)
            mm_pkg::REG_ROWS_OF_A: dim_rows = val;
            mm_pkg::REG_INNER_DIM: dim_inner = val;
            mm_pkg::REG_COLS_OF_B: dim_cols = val;
            default:               return;
        endcase
        load_pos = 0;
    endtask

    task automatic absorb_element(input logic signed [mm_pkg::ELEM_W-1:0] e);
        int nr, nk, nc, size_a, size_b, i, j, k;
        logic signed [63:0] acc;
        logic signed [63:0] sat;
        product_word_t word;
        nr = clamp_dim(dim_rows);
        nk = clamp_dim(dim_inner);
        nc = clamp_dim(dim_cols);
        size_a = nr * nk;
        size_b = nk * nc;
        if (load_pos >= size_a + size_b)
            load_pos = 0;
        if (load_pos < size_a)
            a_store[load_pos % STORE_DEPTH] = e;
        else
            b_store[(load_pos - size_a) % STORE_DEPTH] = e;
        load_pos++;
        if (load_pos < size_a + size_b)
            return;
        load_pos = 0;
        for (i = 0; i < nr; i++)
        begin
            for (j = 0; j < nc; j++)
            begin
                acc = '0;
                for (k = 0; k < nk; k++)
                    acc = acc + a_store[(i * nk + k) % STORE_DEPTH] *
                                b_store[(k * nc + j) % STORE_DEPTH];
                if (acc > Q_MAX)
                    sat = Q_MAX;
                else if (acc < Q_MIN)
                    sat = Q_MIN;
                else
                    sat = acc;
                word.value = sat[mm_pkg::PROD_W-1:0];
                word.row = mm_pkg::IDX_W'(i);
                word.col = mm_pkg::IDX_W'(j);
                word.last = (i == nr - 1) && (j == nc - 1);
                pending_products.push_back(word);
            end
        end
    endtask

    task automatic report_mismatch(input product_word_t want, input product_word_t seen,
                                   input bit unexpected);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            if (unexpected)
                $display("unexpected word: value %h row %0d col %0d last %b",
                         seen.value, seen.row, seen.col, seen.last);
            else
                $display("mismatch: expected value %h row %0d col %0d last %b, got %h %0d %0d %b",
                         want.value, want.row, want.col, want.last,
                         seen.value, seen.row, seen.col, seen.last);
        end
    endtask

    always @(posedge clk)
    begin : check_words
        product_word_t seen;
        product_word_t want;
        if (rst_n && pop && !empty)
        begin
            seen = {product_element, out_row, out_col, last};
            if (pending_products.size() == 0)
                report_mismatch(seen, seen, 1'b1);
            else
            begin
                want = pending_products.pop_front();
                if (seen.value !== want.value || seen.row !== want.row ||
                    seen.col !== want.col || seen.last !== want.last)
                    report_mismatch(want, seen, 1'b0);
            end
        end
    end

    // result side stalls in random bursts
    always @(negedge clk)
    begin
        if (pop_gap > 0)
        begin
            pop_gap = pop_gap - 1;
            pop <= 1'b0;
        end
        else if (idle_enabled && $urandom_range(0, 7) == 0)
        begin
            pop_gap = $urandom_range(0, 12);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    task automatic push_word(input logic [mm_pkg::ELEM_W-1:0] w);
        if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        push <= 1'b1;
        element <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        absorb_element(w);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_words(input int n);
        int i;
        for (i = 0; i < n; i++)
            push_word(pick_element());
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_products.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mm_pkg::DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_config(idx, val);
        @(negedge clk);
    endtask

    task automatic set_dims(input logic [2:0] which, input logic [mm_pkg::DIM_W-1:0] r,
                            input logic [mm_pkg::DIM_W-1:0] k,
                            input logic [mm_pkg::DIM_W-1:0] c);
        wait_drained();
        if (which & SET_ROWS)
            write_reg(mm_pkg::REG_ROWS_OF_A, r);
        if (which & SET_INNER)
            write_reg(mm_pkg::REG_INNER_DIM, k);
        if (which & SET_COLS)
            write_reg(mm_pkg::REG_COLS_OF_B, c);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_dims();
        send_random_words(2 * MAX_DIM * MAX_DIM);
        wait_drained();
    endtask

    task automatic test_dim_clamp();
        set_dims(SET_ALL, 4'd0, 4'd0, 4'd0);
        push_word(16'h7FFF);
        push_word(16'h8000);
        set_dims(SET_ALL, 4'd15, 4'd0, 4'd1);
        send_random_words(MAX_DIM + 1);
    endtask

    task automatic test_saturation();
        int i;
        set_dims(SET_ALL, 4'd1, 4'd2, 4'd1);
        for (i = 0; i < 4; i++)
            push_word(16'h8000);
        set_dims(SET_INNER, 4'd1, 4'd3, 4'd1);
        for (i = 0; i < 3; i++)
            push_word(16'h7FFF);
        for (i = 0; i < 3; i++)
            push_word(16'h8000);
    endtask

    task automatic test_load_restart();
        set_dims(SET_ALL, 4'd1, 4'd1, 4'd2);
        send_random_words(2);
        set_dims(SET_COLS, 4'd1, 4'd1, 4'd2);
        send_random_words(3);
        send_random_words(1);
        wait_drained();
        write_reg(REG_UNUSED, 4'hF);
        cfg_valid <= 1'b0;
        send_random_words(2);
    endtask

    task automatic test_random_loads(input int stop_at, input bit allow_idle);
        int load_len, cut;
        bit must_write;
        must_write = 1'b1;
        while (words_sent < stop_at)
        begin
            idle_enabled = allow_idle && ($urandom_range(0, 3) != 0);
            if (must_write || $urandom_range(0, 2) != 0)
            begin
                set_dims(must_write ? SET_ALL : 3'($urandom_range(1, 7)),
                         pick_dim(), pick_dim(), pick_dim());
                must_write = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
                wait_drained();
            load_len = clamp_dim(dim_rows) * clamp_dim(dim_inner) +
                       clamp_dim(dim_inner) * clamp_dim(dim_cols);
            cut = load_len;
            if (allow_idle && $urandom_range(0, 7) == 0)
            begin
                // broken load, dropped by the next register write
                cut = $urandom_range(1, load_len - 1);
                must_write = 1'b1;
            end
            send_random_words(cut);
        end
        if (must_write)
            set_dims(SET_ROWS, pick_dim(), 4'd1, 4'd1);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < STORE_DEPTH; i++)
        begin
            a_store[i] = '0;
            b_store[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_dims();
        test_dim_clamp();
        test_saturation();
        test_load_restart();
        test_random_loads(330, 1'b1);
        idle_enabled = 1'b0;
        test_random_loads(360, 1'b0);

        wait_drained();
        repeat (4 * SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_products.size() == 0)
            $display("matrix_multiply regression: pass");
        else
            $display("matrix_multiply regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
design/mm_pkg.sv
design/mm_ram.sv
design/mm_queue.sv
design/mm_front.sv
design/mm_back.sv
design/matrix_multiply.sv
tb/tb_matrix_multiply.sv
